FILE: design/cerm_pkg.sv
`default_nettype none

package cerm_pkg;

  // Field and state widths
  localparam int TPS_W      = 8;
  localparam int THR_W      = 15;
  localparam int CUR_W      = 16;
  localparam int MV_W       = 16;
  localparam int PROD_W     = THR_W + MV_W;
  localparam int HRS_W      = 21;
  localparam int MS_W       = 6;
  localparam int SEC_W      = 32;
  localparam int CHG_W      = 48;
  localparam int NRG_W      = 63;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [TPS_W-1:0] TPS_RESET = 8'd10;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;

  // Last value of a minute or second digit before it rolls over
  localparam logic [MS_W-1:0] LAST_MS = 6'd59;

  // Saturation limits
  localparam logic [CHG_W-1:0] CHARGE_MAX = '1;
  localparam logic [NRG_W-1:0] ENERGY_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS = 2'd0,
    CFG_THR = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [TPS_W-1:0] tps;
    logic [THR_W-1:0] thr;
  } cfg_t;

  // Registered measurement between the front stage and the accumulator
  typedef struct packed {
    logic              clear;
    logic              active;
    logic [THR_W-1:0]  cur;
    logic [PROD_W-1:0] prod;
  } meas_t;

  typedef struct packed {
    logic             pulse;
    logic [HRS_W-1:0] hours;
    logic [MS_W-1:0]  minutes;
    logic [MS_W-1:0]  seconds;
    logic [CHG_W-1:0] charge;
    logic [NRG_W-1:0] energy;
  } res_t;

endpackage

`default_nettype wire

FILE: design/cerm_in_if.sv
`default_nettype none

interface cerm_in_if;
  import cerm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [CUR_W-1:0] current_ma;
  logic        [MV_W-1:0]  bus_mv;

  modport source (output valid, output req_type, output current_ma, output bus_mv,
                  input ready);
  modport sink   (input valid, input req_type, input current_ma, input bus_mv,
                  output ready);
endinterface

`default_nettype wire

FILE: design/cerm_out_if.sv
`default_nettype none

interface cerm_out_if;
  import cerm_pkg::*;

  logic             valid;
  logic             ready;
  logic             show_pulse;
  logic [HRS_W-1:0] hours;
  logic [MS_W-1:0]  minutes;
  logic [MS_W-1:0]  seconds;
  logic [CHG_W-1:0] charge_sum;
  logic [NRG_W-1:0] energy_sum;

  modport source (output valid, output show_pulse, output hours, output minutes,
                  output seconds, output charge_sum, output energy_sum, input ready);
  modport sink   (input valid, input show_pulse, input hours, input minutes,
                  input seconds, input charge_sum, input energy_sum, output ready);
endinterface

`default_nettype wire

FILE: design/cerm_cfg_if.sv
`default_nettype none

interface cerm_cfg_if;
  import cerm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/cerm_cfg_regs.sv
`default_nettype none

module cerm_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  cerm_cfg_if.sink            cfg_ch,
  output      cerm_pkg::cfg_t cfg
);
  import cerm_pkg::*;

  logic [TPS_W-1:0] tps_r, tps_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;

  // Writes are always accepted
  assign cfg_ch.ready = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    tps_nxt = tps_r;
    thr_nxt = thr_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TPS: tps_nxt = cfg_ch.data[TPS_W-1:0];
        CFG_THR: thr_nxt = cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      thr_r <= THR_RESET;
    end else begin
      tps_r <= tps_nxt;
      thr_r <= thr_nxt;
    end
  end

  assign cfg.tps = tps_r;
  assign cfg.thr = thr_r;

endmodule

`default_nettype wire

FILE: design/cerm_meas_stage.sv
`default_nettype none

module cerm_meas_stage (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic                    req_type,
  input  wire logic signed [cerm_pkg::CUR_W-1:0] current_ma,
  input  wire logic [cerm_pkg::MV_W-1:0]  bus_mv,
  input  wire logic [cerm_pkg::THR_W-1:0] thr,
  output      cerm_pkg::meas_t          meas
);
  import cerm_pkg::*;

  meas_t meas_r, meas_nxt;

  // Threshold compare and power product; negative current is never active
  always_comb begin
    meas_nxt.clear  = req_type;
    meas_nxt.cur    = current_ma[THR_W-1:0];
    meas_nxt.active = !current_ma[CUR_W-1] && (current_ma[THR_W-1:0] > thr);
    meas_nxt.prod   = PROD_W'(current_ma[THR_W-1:0]) * PROD_W'(bus_mv);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meas_r <= meas_nxt;
    end
  end

  assign meas = meas_r;

endmodule

`default_nettype wire

FILE: design/cerm_acc_core.sv
`default_nettype none

module cerm_acc_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire cerm_pkg::meas_t         meas,
  input  wire logic [cerm_pkg::TPS_W-1:0] tps,
  output      cerm_pkg::res_t          res
);
  import cerm_pkg::*;

  logic [TPS_W-1:0] tick_r, tick_nxt;
  logic [SEC_W-1:0] esec_r, esec_nxt;
  logic [HRS_W-1:0] hrs_r, hrs_nxt;
  logic [MS_W-1:0]  min_r, min_nxt;
  logic [MS_W-1:0]  sec_r, sec_nxt;
  logic [CHG_W-1:0] charge_r, charge_nxt;
  logic [NRG_W-1:0] energy_r, energy_nxt;
  res_t             res_r, res_nxt;

  logic [TPS_W-1:0] tick_inc;
  logic             roll;
  logic [CHG_W:0]   charge_add;
  logic [NRG_W:0]   energy_add;

  // Prescaler and saturating sums
  assign tick_inc   = tick_r + TPS_W'(1);
  assign roll       = (tick_inc >= tps);
  assign charge_add = {1'b0, charge_r} + (CHG_W + 1)'(meas.cur);
  assign energy_add = {1'b0, energy_r} + (NRG_W + 1)'(meas.prod);

  // State update; h/m/s track the seconds count digit by digit
  always_comb begin
    tick_nxt   = tick_r;
    esec_nxt   = esec_r;
    hrs_nxt    = hrs_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    charge_nxt = charge_r;
    energy_nxt = energy_r;
    if (meas.clear) begin
      esec_nxt   = '0;
      hrs_nxt    = '0;
      min_nxt    = '0;
      sec_nxt    = '0;
      charge_nxt = '0;
    end else begin
      tick_nxt = roll ? '0 : tick_inc;
      if (roll && meas.active) begin
        esec_nxt = esec_r + SEC_W'(1);
        // seconds count wraps to zero: so do the digits
        if (esec_r == '1) begin
          hrs_nxt = '0;
          min_nxt = '0;
          sec_nxt = '0;
        end else if (sec_r != LAST_MS) begin
          sec_nxt = sec_r + MS_W'(1);
        end else begin
          sec_nxt = '0;
          if (min_r != LAST_MS) begin
            min_nxt = min_r + MS_W'(1);
          end else begin
            min_nxt = '0;
            hrs_nxt = hrs_r + HRS_W'(1);
          end
        end
      end
      if (meas.active) begin
        charge_nxt = charge_add[CHG_W] ? CHARGE_MAX : charge_add[CHG_W-1:0];
        energy_nxt = energy_add[NRG_W] ? ENERGY_MAX : energy_add[NRG_W-1:0];
      end
    end
  end

  // Result fields reflect the updated state
  always_comb begin
    res_nxt.pulse   = !meas.clear && (tick_nxt == '0);
    res_nxt.hours   = hrs_nxt;
    res_nxt.minutes = min_nxt;
    res_nxt.seconds = sec_nxt;
    res_nxt.charge  = charge_nxt;
    res_nxt.energy  = energy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      esec_r   <= '0;
      hrs_r    <= '0;
      min_r    <= '0;
      sec_r    <= '0;
      charge_r <= '0;
      energy_r <= '0;
    end else if (adv) begin
      tick_r   <= tick_nxt;
      esec_r   <= esec_nxt;
      hrs_r    <= hrs_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
      charge_r <= charge_nxt;
      energy_r <= energy_nxt;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
    (min_r <= LAST_MS) && (sec_r <= LAST_MS))
    else $error("minute or second digit out of range");

  a_digits_match: assert property (@(posedge clk) disable iff (!rst_n)
    esec_r == (SEC_W'(hrs_r) * SEC_W'(3600) + SEC_W'(min_r) * SEC_W'(60) + SEC_W'(sec_r)))
    else $error("h/m/s digits disagree with seconds count");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && meas.clear) |=> (charge_r == '0) && (esec_r == '0))
    else $error("clear transfer did not zero charge and seconds");

  a_energy_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (energy_r >= $past(energy_r)))
    else $error("energy sum decreased");
`endif

endmodule

`default_nettype wire

FILE: design/charge_energy_runtime_meter_unit.sv
// Charge and energy run-time meter. Each input transfer is either a timer
// tick carrying current (mA, signed) and bus voltage (mV), or a clear event;
// each one yields exactly one result transfer with the display pulse, the
// active run time as hours/minutes/seconds, and raw saturating charge and
// energy sums. One item is accepted every clock cycle unless the output
// stalls. There are two register stages: the first holds the threshold
// compare and the 15x16 current-times-voltage product, the second holds
// the prescaler, run-time digits and the two saturating accumulators that
// update once per item. A full result register lets one more item enter
// the first stage before the input stalls. Configuration writes are
// expected only while the block is idle, and there is no clearing pass
// after reset.
`default_nettype none

module charge_energy_runtime_meter_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cerm_in_if.sink    in_ch,
  cerm_out_if.source out_ch,
  cerm_cfg_if.sink   cfg_ch
);
  import cerm_pkg::*;

  cfg_t  cfg;
  meas_t meas;
  res_t  res;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic adv;
  logic load;

  // Pipeline handshake: stage 1 moves on when the result register frees up
  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || adv;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = load ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  cerm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  cerm_meas_stage u_meas (
    .clk        (clk),
    .load       (load),
    .req_type   (in_ch.req_type),
    .current_ma (in_ch.current_ma),
    .bus_mv     (in_ch.bus_mv),
    .thr        (cfg.thr),
    .meas       (meas)
  );

  cerm_acc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .meas  (meas),
    .tps   (cfg.tps),
    .res   (res)
  );

  // Result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.show_pulse = res.pulse;
  assign out_ch.hours      = res.hours;
  assign out_ch.minutes    = res.minutes;
  assign out_ch.seconds    = res.seconds;
  assign out_ch.charge_sum = res.charge;
  assign out_ch.energy_sum = res.energy;

endmodule

`default_nettype wire
